### sv/radial_dead_zone_stick_top_macros.svh
// assertion macros shared by the stick checker
`ifndef RADIAL_DEAD_ZONE_STICK_TOP_MACROS_SVH
`define RADIAL_DEAD_ZONE_STICK_TOP_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define RDZS_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define RDZS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/rdzs_pkg.sv
// shared constants and types of the radial dead zone stick
`default_nettype none

package rdzs_pkg;

    // field widths
    localparam int COORD_BITS = 12;
    localparam int FRAC_BITS  = 14;
    localparam int RAD_W      = 11;
    localparam int ELAPSED_W  = 16;
    localparam int STICK_W    = 16;
    localparam int CMD_W      = 2;
    localparam int KIND_W     = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;

    // datapath widths
    localparam int OP_W   = (COORD_BITS > RAD_W) ? COORD_BITS : RAD_W;
    localparam int PROD_W = 2 * OP_W;
    localparam int DIV_W  = PROD_W + FRAC_BITS;
    localparam int SUB_W  = DIV_W + 1;
    localparam int Q_W    = FRAC_BITS + 1;
    localparam int CNT_W  = $clog2((Q_W > COORD_BITS) ? Q_W : COORD_BITS);

    typedef logic [CMD_W-1:0]     cmd_t;
    typedef logic [KIND_W-1:0]    kind_t;
    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

    // commands
    localparam cmd_t CMD_BEGIN = 2'd0;
    localparam cmd_t CMD_MOVE  = 2'd1;
    localparam cmd_t CMD_END   = 2'd2;
    localparam cmd_t CMD_TICK  = 2'd3;

    // event kinds
    localparam kind_t KIND_NONE    = 3'd0;
    localparam kind_t KIND_BEGAN   = 3'd1;
    localparam kind_t KIND_MOVED   = 3'd2;
    localparam kind_t KIND_ENDED   = 3'd3;
    localparam kind_t KIND_UPDATED = 3'd4;

    // register indexes
    localparam cfg_idx_t CFG_OUTER  = 2'd0;
    localparam cfg_idx_t CFG_INNER  = 2'd1;
    localparam cfg_idx_t CFG_ENABLE = 2'd2;

    // register reset values
    localparam logic [RAD_W-1:0] OUTER_RESET = RAD_W'(64);
    localparam logic [RAD_W-1:0] INNER_RESET = RAD_W'(0);

endpackage

`default_nettype wire

### sv/rdzs_if.sv
// touch and stick channel interfaces
`default_nettype none

interface rdzs_touch_if
    import rdzs_pkg::*;
();
    logic                         valid;
    logic                         ready;
    logic [CMD_W-1:0]             cmd;
    logic signed [COORD_BITS-1:0] x_pos;
    logic signed [COORD_BITS-1:0] y_pos;
    logic [ELAPSED_W-1:0]         elapsed;

    modport source (output valid, cmd, x_pos, y_pos, elapsed, input ready);
    modport sink   (input valid, cmd, x_pos, y_pos, elapsed, output ready);
endinterface

interface rdzs_stick_if
    import rdzs_pkg::*;
();
    logic                      valid;
    logic                      ready;
    logic [KIND_W-1:0]         event_kind;
    logic signed [STICK_W-1:0] stick_x;
    logic signed [STICK_W-1:0] stick_y;
    logic                      touch_accepted;
    logic [ELAPSED_W-1:0]      elapsed_out;

    modport source (output valid, event_kind, stick_x, stick_y, touch_accepted, elapsed_out,
                    input ready);
    modport sink   (input valid, event_kind, stick_x, stick_y, touch_accepted, elapsed_out,
                    output ready);
endinterface

`default_nettype wire

### sv/radial_dead_zone_stick_top.sv
// Virtual analog stick with a radial dead zone. Each touch item (begin, move, end, tick)
// gives exactly one stick item. A begin, move or end runs through one shared 12x12
// multiplier and one shared subtract/compare unit under a small sequencer: squared
// distance, radius checks, a 12-step bit-serial square root, then two 15-step restoring
// divisions, one per axis. Touch ready stays low while an item is worked on, so the block
// takes one touch item at a time; a begin beyond the outer radius or a point in the dead
// zone drops out before the square root, and a tick, an ignored move or end, or a disabled
// begin goes straight to the hand-off. A finished item sits in an output register, so the
// next touch item is taken while the stick side stalls; the hand-off cycle stretches for
// as long as that register still holds an item nobody has taken. Configuration is a plain
// write port.
`default_nettype none

module radial_dead_zone_stick_top
    import rdzs_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    rdzs_touch_if.sink                 touch,
    rdzs_stick_if.source               stick
);

    // sequencer states
    localparam int ST_W = 4;
    localparam logic [ST_W-1:0] ST_IDLE  = 4'd0;   // waiting for a touch item
    localparam logic [ST_W-1:0] ST_MXX   = 4'd1;   // d2 = x*x
    localparam logic [ST_W-1:0] ST_MYY   = 4'd2;   // d2 += y*y
    localparam logic [ST_W-1:0] ST_MOO   = 4'd3;   // lim = outer*outer (begin only)
    localparam logic [ST_W-1:0] ST_CHKO  = 4'd4;   // reject a begin beyond the outer radius
    localparam logic [ST_W-1:0] ST_MII   = 4'd5;   // lim = inner*inner
    localparam logic [ST_W-1:0] ST_CHKI  = 4'd6;   // dead zone test
    localparam logic [ST_W-1:0] ST_SQRT  = 4'd7;   // one root bit per cycle
    localparam logic [ST_W-1:0] ST_CLAMP = 4'd8;   // r = min(m, outer), r - inner
    localparam logic [ST_W-1:0] ST_MDEN  = 4'd9;   // den = m * (outer - inner)
    localparam logic [ST_W-1:0] ST_MNUM  = 4'd10;  // num = |axis| * (r - inner)
    localparam logic [ST_W-1:0] ST_DIV   = 4'd11;  // one quotient bit per cycle
    localparam logic [ST_W-1:0] ST_OUT   = 4'd12;  // hand item to output register

    // control and architectural state
    logic [ST_W-1:0]  state_reg, state_next;
    logic [RAD_W-1:0] outer_reg;
    logic [RAD_W-1:0] inner_reg;
    logic             enable_reg;
    logic             touching_reg, touching_next;
    logic [STICK_W-1:0] held_x_reg, held_x_next;
    logic [STICK_W-1:0] held_y_reg, held_y_next;
    logic             out_valid_reg, out_valid_next;

    // working registers of the current item
    logic [CMD_W-1:0]      cmd_reg, cmd_next;
    logic [COORD_BITS-1:0] mag_x_reg, mag_x_next;
    logic [COORD_BITS-1:0] mag_y_reg, mag_y_next;
    logic                  neg_x_reg, neg_x_next;
    logic                  neg_y_reg, neg_y_next;
    logic [RAD_W-1:0]      span_reg, span_next;
    logic                  degen_reg, degen_next;
    logic [PROD_W-1:0]     d2_reg, d2_next;
    logic [PROD_W-1:0]     lim_reg, lim_next;
    logic [DIV_W-1:0]      rem_reg, rem_next;
    logic [PROD_W-1:0]     root_reg, root_next;
    logic [PROD_W-1:0]     bit_reg, bit_next;
    logic [DIV_W-1:0]      dsh_reg, dsh_next;
    logic [PROD_W-1:0]     den_reg, den_next;
    logic [RAD_W-1:0]      rmi_reg, rmi_next;
    logic [Q_W-1:0]        q_reg, q_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic                  axis_reg, axis_next;
    logic                  store_reg, store_next;

    // pending result
    logic [KIND_W-1:0]    res_kind_reg, res_kind_next;
    logic [STICK_W-1:0]   res_x_reg, res_x_next;
    logic [STICK_W-1:0]   res_y_reg, res_y_next;
    logic                 res_acc_reg, res_acc_next;
    logic [ELAPSED_W-1:0] res_el_reg, res_el_next;

    // output register
    logic [KIND_W-1:0]    out_kind_reg, out_kind_next;
    logic [STICK_W-1:0]   out_x_reg, out_x_next;
    logic [STICK_W-1:0]   out_y_reg, out_y_next;
    logic                 out_acc_reg, out_acc_next;
    logic [ELAPSED_W-1:0] out_el_reg, out_el_next;

    // shared multiplier
    logic [OP_W-1:0]   mul_a, mul_b;
    logic [PROD_W-1:0] prod;

    // shared subtract/compare unit
    logic [DIV_W-1:0] sub_a, sub_b;
    logic [SUB_W-1:0] diff;
    logic             borrow;

    // helpers
    logic                  accept;
    logic                  out_load;
    logic [COORD_BITS-1:0] in_mag_x, in_mag_y;
    logic [COORD_BITS-1:0] m_val;
    logic [OP_W-1:0]       r_val;
    logic [Q_W-1:0]        q_new;
    logic [STICK_W-1:0]    q_ext;
    logic [STICK_W-1:0]    q_signed;

    assign accept   = touch.valid && (state_reg == ST_IDLE);
    assign out_load = (state_reg == ST_OUT) && (!out_valid_reg || stick.ready);

    assign in_mag_x = touch.x_pos[COORD_BITS-1] ? COORD_BITS'(-touch.x_pos)
                                                : COORD_BITS'(touch.x_pos);
    assign in_mag_y = touch.y_pos[COORD_BITS-1] ? COORD_BITS'(-touch.y_pos)
                                                : COORD_BITS'(touch.y_pos);

    assign prod   = PROD_W'(mul_a) * PROD_W'(mul_b);
    assign diff   = {1'b0, sub_a} - {1'b0, sub_b};
    assign borrow = diff[DIV_W];

    // magnitude m and clamped radius r
    assign m_val = root_reg[COORD_BITS-1:0];
    assign r_val = (OP_W'(m_val) < OP_W'(outer_reg)) ? OP_W'(m_val) : OP_W'(outer_reg);

    // next quotient and its signed form
    assign q_new    = {q_reg[Q_W-2:0], ~borrow};
    assign q_ext    = STICK_W'(q_new);
    assign q_signed = (axis_reg ? neg_y_reg : neg_x_reg) ? -q_ext : q_ext;

    // operand select for the shared units
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        sub_a = '0;
        sub_b = '0;
        unique case (state_reg)
            ST_MXX:
            begin
                mul_a = OP_W'(mag_x_reg);
                mul_b = OP_W'(mag_x_reg);
            end
            ST_MYY:
            begin
                mul_a = OP_W'(mag_y_reg);
                mul_b = OP_W'(mag_y_reg);
            end
            ST_MOO:
            begin
                mul_a = OP_W'(outer_reg);
                mul_b = OP_W'(outer_reg);
            end
            ST_MII:
            begin
                mul_a = OP_W'(inner_reg);
                mul_b = OP_W'(inner_reg);
            end
            ST_MDEN:
            begin
                mul_a = OP_W'(m_val);
                mul_b = OP_W'(span_reg);
            end
            ST_MNUM:
            begin
                mul_a = axis_reg ? OP_W'(mag_y_reg) : OP_W'(mag_x_reg);
                mul_b = OP_W'(rmi_reg);
            end
            ST_CHKO:
            begin
                // borrow means d2 > outer^2
                sub_a = DIV_W'(lim_reg);
                sub_b = DIV_W'(d2_reg);
            end
            ST_CHKI:
            begin
                // no borrow means d2 >= inner^2
                sub_a = DIV_W'(d2_reg);
                sub_b = DIV_W'(lim_reg);
            end
            ST_SQRT:
            begin
                sub_a = rem_reg;
                sub_b = DIV_W'(root_reg + bit_reg);
            end
            ST_DIV:
            begin
                sub_a = rem_reg;
                sub_b = dsh_reg;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        touching_next  = touching_reg;
        held_x_next    = held_x_reg;
        held_y_next    = held_y_reg;
        out_valid_next = out_valid_reg && !stick.ready;

        cmd_next     = cmd_reg;
        mag_x_next   = mag_x_reg;
        mag_y_next   = mag_y_reg;
        neg_x_next   = neg_x_reg;
        neg_y_next   = neg_y_reg;
        span_next    = span_reg;
        degen_next   = degen_reg;
        d2_next      = d2_reg;
        lim_next     = lim_reg;
        rem_next     = rem_reg;
        root_next    = root_reg;
        bit_next     = bit_reg;
        dsh_next     = dsh_reg;
        den_next     = den_reg;
        rmi_next     = rmi_reg;
        q_next       = q_reg;
        cnt_next     = cnt_reg;
        axis_next    = axis_reg;
        store_next   = store_reg;

        res_kind_next = res_kind_reg;
        res_x_next    = res_x_reg;
        res_y_next    = res_y_reg;
        res_acc_next  = res_acc_reg;
        res_el_next   = res_el_reg;

        out_kind_next = out_kind_reg;
        out_x_next    = out_x_reg;
        out_y_next    = out_y_reg;
        out_acc_next  = out_acc_reg;
        out_el_next   = out_el_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    cmd_next      = touch.cmd;
                    mag_x_next    = in_mag_x;
                    mag_y_next    = in_mag_y;
                    neg_x_next    = touch.x_pos[COORD_BITS-1];
                    neg_y_next    = touch.y_pos[COORD_BITS-1];
                    span_next     = RAD_W'(outer_reg - inner_reg);
                    degen_next    = (outer_reg <= inner_reg);
                    store_next    = 1'b0;
                    res_kind_next = KIND_NONE;
                    res_x_next    = '0;
                    res_y_next    = '0;
                    res_acc_next  = 1'b0;
                    res_el_next   = '0;
                    state_next    = ST_OUT;
                    unique case (touch.cmd)
                        CMD_BEGIN:
                        begin
                            if (enable_reg)
                            begin
                                state_next = ST_MXX;
                            end
                        end
                        CMD_MOVE, CMD_END:
                        begin
                            if (touching_reg)
                            begin
                                state_next = ST_MXX;
                            end
                        end
                        CMD_TICK:
                        begin
                            // report the held vector while touching
                            if (touching_reg)
                            begin
                                res_kind_next = KIND_UPDATED;
                                res_x_next    = held_x_reg;
                                res_y_next    = held_y_reg;
                                res_el_next   = touch.elapsed;
                            end
                        end
                        default:
                        begin
                            state_next = ST_OUT;
                        end
                    endcase
                end
            end
            ST_MXX:
            begin
                d2_next    = prod;
                state_next = ST_MYY;
            end
            ST_MYY:
            begin
                d2_next    = d2_reg + prod;
                state_next = (cmd_reg == CMD_BEGIN) ? ST_MOO : ST_MII;
            end
            ST_MOO:
            begin
                lim_next   = prod;
                state_next = ST_CHKO;
            end
            ST_CHKO:
            begin
                // begin beyond the outer radius: a none item, no state change
                state_next = borrow ? ST_OUT : ST_MII;
            end
            ST_MII:
            begin
                lim_next   = prod;
                state_next = ST_CHKI;
            end
            ST_CHKI:
            begin
                store_next = 1'b1;
                unique case (cmd_reg)
                    CMD_BEGIN:
                    begin
                        res_kind_next = KIND_BEGAN;
                        res_acc_next  = 1'b1;
                    end
                    CMD_MOVE:
                    begin
                        res_kind_next = borrow ? KIND_NONE : KIND_MOVED;
                    end
                    CMD_END:
                    begin
                        res_kind_next = KIND_ENDED;
                    end
                    default:
                    begin
                        res_kind_next = KIND_NONE;
                    end
                endcase
                if (borrow)
                begin
                    // inside the dead zone: zero vector
                    state_next = ST_OUT;
                end
                else
                begin
                    rem_next   = DIV_W'(d2_reg);
                    root_next  = '0;
                    bit_next   = PROD_W'(1) << (2 * COORD_BITS - 2);
                    cnt_next   = CNT_W'(COORD_BITS - 1);
                    state_next = ST_SQRT;
                end
            end
            ST_SQRT:
            begin
                if (!borrow)
                begin
                    rem_next  = diff[DIV_W-1:0];
                    root_next = (root_reg >> 1) + bit_reg;
                end
                else
                begin
                    root_next = root_reg >> 1;
                end
                bit_next = bit_reg >> 2;
                if (cnt_reg == '0)
                begin
                    state_next = ST_CLAMP;
                end
                else
                begin
                    cnt_next = cnt_reg - CNT_W'(1);
                end
            end
            ST_CLAMP:
            begin
                rmi_next = RAD_W'(r_val - OP_W'(inner_reg));
                // zero magnitude or outer not above inner gives a zero vector
                state_next = (degen_reg || (m_val == '0)) ? ST_OUT : ST_MDEN;
            end
            ST_MDEN:
            begin
                den_next   = prod;
                axis_next  = 1'b0;
                state_next = ST_MNUM;
            end
            ST_MNUM:
            begin
                rem_next   = DIV_W'(prod) << FRAC_BITS;
                dsh_next   = DIV_W'(den_reg) << FRAC_BITS;
                q_next     = '0;
                cnt_next   = CNT_W'(Q_W - 1);
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (!borrow)
                begin
                    rem_next = diff[DIV_W-1:0];
                end
                dsh_next = dsh_reg >> 1;
                q_next   = q_new;
                if (cnt_reg == '0)
                begin
                    if (axis_reg)
                    begin
                        res_y_next = q_signed;
                        state_next = ST_OUT;
                    end
                    else
                    begin
                        res_x_next = q_signed;
                        axis_next  = 1'b1;
                        state_next = ST_MNUM;
                    end
                end
                else
                begin
                    cnt_next = cnt_reg - CNT_W'(1);
                end
            end
            ST_OUT:
            begin
                if (out_load)
                begin
                    out_valid_next = 1'b1;
                    out_kind_next  = res_kind_reg;
                    out_x_next     = res_x_reg;
                    out_y_next     = res_y_reg;
                    out_acc_next   = res_acc_reg;
                    out_el_next    = res_el_reg;
                    if (store_reg)
                    begin
                        held_x_next   = res_x_reg;
                        held_y_next   = res_y_reg;
                        touching_next = (cmd_reg != CMD_END);
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state, configuration and held vector
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            touching_reg  <= 1'b0;
            held_x_reg    <= '0;
            held_y_reg    <= '0;
            out_valid_reg <= 1'b0;
            outer_reg     <= OUTER_RESET;
            inner_reg     <= INNER_RESET;
            enable_reg    <= 1'b1;
        end
        else
        begin
            state_reg     <= state_next;
            touching_reg  <= touching_next;
            held_x_reg    <= held_x_next;
            held_y_reg    <= held_y_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_OUTER:  outer_reg  <= cfg_data[RAD_W-1:0];
                    CFG_INNER:  inner_reg  <= cfg_data[RAD_W-1:0];
                    CFG_ENABLE: enable_reg <= cfg_data[0];
                    default:
                    begin
                        enable_reg <= enable_reg;
                    end
                endcase
            end
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        mag_x_reg    <= mag_x_next;
        mag_y_reg    <= mag_y_next;
        neg_x_reg    <= neg_x_next;
        neg_y_reg    <= neg_y_next;
        span_reg     <= span_next;
        degen_reg    <= degen_next;
        d2_reg       <= d2_next;
        lim_reg      <= lim_next;
        rem_reg      <= rem_next;
        root_reg     <= root_next;
        bit_reg      <= bit_next;
        dsh_reg      <= dsh_next;
        den_reg      <= den_next;
        rmi_reg      <= rmi_next;
        q_reg        <= q_next;
        cnt_reg      <= cnt_next;
        axis_reg     <= axis_next;
        store_reg    <= store_next;
        res_kind_reg <= res_kind_next;
        res_x_reg    <= res_x_next;
        res_y_reg    <= res_y_next;
        res_acc_reg  <= res_acc_next;
        res_el_reg   <= res_el_next;
        out_kind_reg <= out_kind_next;
        out_x_reg    <= out_x_next;
        out_y_reg    <= out_y_next;
        out_acc_reg  <= out_acc_next;
        out_el_reg   <= out_el_next;
    end

    // channel outputs
    assign touch.ready          = (state_reg == ST_IDLE);
    assign stick.valid          = out_valid_reg;
    assign stick.event_kind     = out_kind_reg;
    assign stick.stick_x        = out_x_reg;
    assign stick.stick_y        = out_y_reg;
    assign stick.touch_accepted = out_acc_reg;
    assign stick.elapsed_out    = out_el_reg;

endmodule

`default_nettype wire

### sv/rdzs_checker.sv
// port-level checks of the stick block and their bind
`default_nettype none

`include "radial_dead_zone_stick_top_macros.svh"

module rdzs_checker
    import rdzs_pkg::*;
(
    input wire logic                 clk,
    input wire logic                 rst_n,
    input wire logic                 touch_valid,
    input wire logic                 touch_ready,
    input wire logic                 stick_valid,
    input wire logic                 stick_ready,
    input wire logic [KIND_W-1:0]    event_kind,
    input wire logic [STICK_W-1:0]   stick_x,
    input wire logic [STICK_W-1:0]   stick_y,
    input wire logic                 touch_accepted,
    input wire logic [ELAPSED_W-1:0] elapsed_out
);

    // a stalled item stays on offer
    `RDZS_ASSERT_NEXT(a_stall_hold, stick_valid && !stick_ready, stick_valid, "stick item dropped")

    // one item at a time: busy right after taking a touch item
    `RDZS_ASSERT_NEXT(a_busy_after_take, touch_valid && touch_ready, !touch_ready, "ready after take")

    // a none item carries zero in every field
    `RDZS_ASSERT_IMPL(a_none_zero, stick_valid && event_kind == KIND_NONE, stick_x == '0 && stick_y == '0 && !touch_accepted && elapsed_out == '0, "none item not zero")

    // only a began item claims the touch
    `RDZS_ASSERT_IMPL(a_claim_began, stick_valid, touch_accepted == (event_kind == KIND_BEGAN), "claim without began")

    // elapsed only rides on updated items
    `RDZS_ASSERT_IMPL(a_elapsed_tick, stick_valid && event_kind != KIND_UPDATED, elapsed_out == '0, "elapsed off tick")

endmodule

bind radial_dead_zone_stick_top rdzs_checker u_rdzs_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .touch_valid    (touch.valid),
    .touch_ready    (touch.ready),
    .stick_valid    (stick.valid),
    .stick_ready    (stick.ready),
    .event_kind     (stick.event_kind),
    .stick_x        (stick.stick_x),
    .stick_y        (stick.stick_y),
    .touch_accepted (stick.touch_accepted),
    .elapsed_out    (stick.elapsed_out)
);

`default_nettype wire
